// File: src/msfsa_pkg.sv
package msfsa_pkg;

	localparam int STORE_DEPTH = 1024;
	localparam int SLOT_W = $clog2(STORE_DEPTH);
	localparam int IN_QUEUE_DEPTH = 4;
	localparam int IN_CNT_W = $clog2(IN_QUEUE_DEPTH + 1);
	localparam int IN_PTR_W = $clog2(IN_QUEUE_DEPTH);

	localparam logic [31:0] QNAN_DEFAULT = 32'hffc0_0000;

	localparam logic FMT_SINGLE = 1'b0;
	localparam logic FMT_HALF = 1'b1;

	typedef struct packed {
		logic [31:0] sample;
		logic [9:0]  position;
		logic        first_source;
		logic        last_source;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALIGN,
		ST_ADD,
		ST_ROUND,
		ST_EMIT
	} back_state_t;

	function automatic logic [31:0] half_to_single(input logic [15:0] h);
		logic [31:0] sgn;
		logic [9:0]  man;
		logic [3:0]  p;
		logic [31:0] wide;
		sgn = {h[15], 31'b0};
		man = h[9:0];
		p = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (man[i]) p = 4'(i);
		end
		wide = 32'(man) << (5'd23 - 5'(p));
		if (h[14:10] == 5'd0) begin
			if (man == 10'd0) half_to_single = sgn;
			else half_to_single = sgn | {1'b0, 8'(8'd103 + 8'(p)), wide[22:0]};
		end else if (h[14:10] == 5'h1f) begin
			half_to_single = sgn | 32'h7f80_0000 | {9'b0, man, 13'b0};
		end else begin
			half_to_single = sgn + ((32'(h[14:0]) + 32'h1_c000) << 13);
		end
	endfunction

	function automatic logic [15:0] single_to_half(input logic [31:0] f);
		logic [31:0] sgn;
		logic [31:0] ex;
		logic [31:0] man;
		logic [31:0] r;
		logic [31:0] res;
		sgn = {16'b0, f[31], 15'b0};
		ex = f & 32'h7f80_0000;
		res = 32'd0;
		if (ex >= 32'h4780_0000) begin
			res = sgn + 32'h7c00;
			if (ex == 32'h7f80_0000 && f[22:0] != 23'd0) begin
				r = 32'h7c00 + (32'(f[22:0]) >> 13);
				if (r == 32'h7c00) r = r + 32'd1;
				res = sgn + r;
			end
		end else if (ex <= 32'h3800_0000) begin
			if (ex < 32'h3300_0000) begin
				res = sgn;
			end else begin
				man = (32'h0080_0000 + 32'(f[22:0])) >> (8'd113 - f[30:23]);
				man = man + 32'h1000;
				res = sgn + (man >> 13);
			end
		end else begin
			man = 32'(f[22:0]) + 32'h1000;
			res = sgn + ((ex - 32'h3800_0000) >> 13) + (man >> 13);
		end
		single_to_half = res[15:0];
	endfunction

endpackage

// File: src/msfsa_front.sv
module msfsa_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_format,
	input  logic [31:0]        sample_bits,
	input  logic [9:0]         position,
	input  logic               first_source,
	input  logic               last_source,
	input  logic               push,
	output logic               full,
	input  logic               item_pop,
	output logic               item_empty,
	output msfsa_pkg::item_t   item
);

	msfsa_pkg::item_t slot_q [msfsa_pkg::IN_QUEUE_DEPTH];
	logic [msfsa_pkg::IN_PTR_W-1:0] wr_q, rd_q;
	logic [msfsa_pkg::IN_CNT_W-1:0] cnt_q;
	msfsa_pkg::item_t in_item;
	logic do_push, do_pop;

	// samples are widened here so the back end only ever sees single patterns
	always_comb begin
		in_item.sample = (sample_format == msfsa_pkg::FMT_HALF)
			? msfsa_pkg::half_to_single(sample_bits[15:0]) : sample_bits;
		in_item.position = position;
		in_item.first_source = first_source;
		in_item.last_source = last_source;
	end

	assign full = (cnt_q == msfsa_pkg::IN_CNT_W'(msfsa_pkg::IN_QUEUE_DEPTH));
	assign item_empty = (cnt_q == '0);
	assign item = slot_q[rd_q];
	assign do_push = push && !full;
	assign do_pop = item_pop && !item_empty;

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (!do_push && do_pop) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// File: src/msfsa_back.sv
module msfsa_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_format,
	output logic               item_pop,
	input  logic               item_empty,
	input  msfsa_pkg::item_t   item,
	output logic               empty,
	input  logic               pop,
	output logic [31:0]        sum_bits,
	output logic [9:0]         out_position
);

	logic [31:0] mem [msfsa_pkg::STORE_DEPTH];

	msfsa_pkg::back_state_t state_q, state_d;
	msfsa_pkg::item_t cur_q;
	logic [31:0] rdata_q;
	logic [31:0] sum_q;
	logic [31:0] sum_d;

	// alignment stage
	logic        spec_s1, sign_s1, sub_s1;
	logic [31:0] spec_val_s1;
	logic [7:0]  exp_s1;
	logic [26:0] ma_s1, mb_s1;
	// add stage
	logic        spec_s2, sign_s2, sub_s2;
	logic [31:0] spec_val_s2;
	logic [7:0]  exp_s2;
	logic [27:0] sum_s2;
	logic [4:0]  lz_s2;

	// output queue, two entries
	logic [31:0] osum_q [2];
	logic [9:0]  opos_q [2];
	logic        owr_q, ord_q;
	logic [1:0]  ocnt_q;
	logic        ofull, opush, opop;

	assign item_pop = (state_q == msfsa_pkg::ST_IDLE) && !item_empty;
	assign ofull = (ocnt_q == 2'd2);
	assign opush = (state_q == msfsa_pkg::ST_EMIT) && !ofull;
	assign opop = pop && !empty;
	assign empty = (ocnt_q == 2'd0);
	assign sum_bits = osum_q[ord_q];
	assign out_position = opos_q[ord_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= msfsa_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			msfsa_pkg::ST_IDLE:  if (!item_empty) state_d = msfsa_pkg::ST_ALIGN;
			msfsa_pkg::ST_ALIGN: state_d = msfsa_pkg::ST_ADD;
			msfsa_pkg::ST_ADD:   state_d = msfsa_pkg::ST_ROUND;
			msfsa_pkg::ST_ROUND: state_d = cur_q.last_source ? msfsa_pkg::ST_EMIT
				: msfsa_pkg::ST_IDLE;
			msfsa_pkg::ST_EMIT:  if (!ofull) state_d = msfsa_pkg::ST_IDLE;
			default:             state_d = msfsa_pkg::ST_IDLE;
		endcase
	end

	// store read on take-up, write-back at rounding
	always_ff @(posedge clk) begin
		if (item_pop) begin
			cur_q <= item;
			rdata_q <= mem[item.position[msfsa_pkg::SLOT_W-1:0]];
		end
		if (state_q == msfsa_pkg::ST_ROUND)
			mem[cur_q.position[msfsa_pkg::SLOT_W-1:0]] <= sum_d;
	end

	// ---- alignment ----
	logic [31:0] a, b, big, sml;
	logic        a_nan, b_nan, a_inf, b_inf;
	logic [7:0]  e_big, e_sml, dexp;
	logic [26:0] m_big, m_sml, mask, shifted;
	logic        sticky;

	always_comb begin
		a = cur_q.first_source ? 32'd0 : rdata_q;
		b = cur_q.sample;
		a_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
		b_nan = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
		a_inf = (a[30:0] == 31'h7f80_0000);
		b_inf = (b[30:0] == 31'h7f80_0000);
		if (a[30:0] >= b[30:0]) begin
			big = a;
			sml = b;
		end else begin
			big = b;
			sml = a;
		end
		e_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		e_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
		dexp = e_big - e_sml;
		m_big = {big[30:23] != 8'd0, big[22:0], 3'b000};
		m_sml = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
		mask = 27'd0;
		if (dexp >= 8'd27) begin
			shifted = 27'd0;
			sticky = |m_sml;
		end else begin
			mask = (27'd1 << dexp[4:0]) - 27'd1;
			shifted = m_sml >> dexp[4:0];
			sticky = |(m_sml & mask);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == msfsa_pkg::ST_ALIGN) begin
			spec_s1 <= a_nan || b_nan || a_inf || b_inf;
			priority if (a_nan) spec_val_s1 <= a | 32'h0040_0000;
			else if (b_nan) spec_val_s1 <= b | 32'h0040_0000;
			else if (a_inf && b_inf && (a[31] != b[31])) spec_val_s1 <= msfsa_pkg::QNAN_DEFAULT;
			else if (a_inf) spec_val_s1 <= a;
			else spec_val_s1 <= b;
			sign_s1 <= big[31];
			sub_s1 <= a[31] ^ b[31];
			exp_s1 <= e_big;
			ma_s1 <= m_big;
			mb_s1 <= {shifted[26:1], shifted[0] | sticky};
		end
	end

	// ---- add ----
	logic [27:0] raw_sum;
	logic [4:0]  lz;

	always_comb begin
		raw_sum = sub_s1 ? (28'(ma_s1) - 28'(mb_s1)) : (28'(ma_s1) + 28'(mb_s1));
		lz = 5'd27;
		for (int i = 0; i < 27; i++) begin
			if (raw_sum[i]) lz = 5'(26 - i);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == msfsa_pkg::ST_ADD) begin
			spec_s2 <= spec_s1;
			spec_val_s2 <= spec_val_s1;
			sign_s2 <= sign_s1;
			sub_s2 <= sub_s1;
			exp_s2 <= exp_s1;
			sum_s2 <= raw_sum;
			lz_s2 <= lz;
		end
	end

	// ---- normalise and round to nearest even ----
	logic [26:0] norm;
	logic [8:0]  ef;
	logic [7:0]  lsh;
	logic        rnd;

	always_comb begin
		norm = 27'd0;
		ef = 9'd0;
		lsh = 8'd0;
		rnd = 1'b0;
		if (sum_s2[27]) begin
			norm = {sum_s2[27:2], sum_s2[1] | sum_s2[0]};
			ef = 9'(exp_s2) + 9'd1;
		end else begin
			lsh = (8'(lz_s2) < exp_s2 - 8'd1) ? 8'(lz_s2) : exp_s2 - 8'd1;
			norm = sum_s2[26:0] << lsh[4:0];
			ef = norm[26] ? 9'(exp_s2 - lsh) : 9'd0;
		end
		rnd = norm[2] && (norm[1] || norm[0] || norm[3]);
		if (spec_s2) sum_d = spec_val_s2;
		else if (sum_s2 == 28'd0) sum_d = {sign_s2 && !sub_s2, 31'd0};
		else if (ef >= 9'd255) sum_d = {sign_s2, 31'h7f80_0000};
		else sum_d = {sign_s2, ef[7:0], norm[25:3]} + 32'(rnd);
	end

	always_ff @(posedge clk) begin
		if (state_q == msfsa_pkg::ST_ROUND) sum_q <= sum_d;
	end

	always_ff @(posedge clk) begin
		if (opush) begin
			osum_q[owr_q] <= (sample_format == msfsa_pkg::FMT_HALF)
				? {16'd0, msfsa_pkg::single_to_half(sum_q)} : sum_q;
			opos_q[owr_q] <= cur_q.position;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q <= 1'b0;
			ord_q <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (opush) owr_q <= !owr_q;
			if (opop) ord_q <= !ord_q;
			if (opush && !opop) ocnt_q <= ocnt_q + 2'd1;
			else if (!opush && opop) ocnt_q <= ocnt_q - 2'd1;
		end
	end

	a_ocnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q <= 2'd2) else $error("output queue overfilled");
	a_align_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == msfsa_pkg::ST_ALIGN |-> $past(item_pop))
		else $error("alignment without a taken item");
	a_no_emit_unless_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == msfsa_pkg::ST_ROUND && !cur_q.last_source |=> state_q == msfsa_pkg::ST_IDLE)
		else $error("result emitted for a non-final source");
	a_take_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop |-> state_q == msfsa_pkg::ST_IDLE) else $error("item taken while busy");

endmodule

// File: src/multi_source_float_sum_accumulator.sv
// Sums samples that share an element position across several source streams into a
// 1024-entry single-precision store. A sample flagged first_source starts its entry from
// +0, others add to it, and one flagged last_source emits the finished sum on the result
// queue. sample_format (reset 1) selects half samples and half results, else single.
// Items enter a four-deep queue after widening; the back end then handles one item at
// a time (store read, align, add, normalise/round with write-back, then emit for a last
// source, waiting while the result queue is full) and takes no new item until done.
// Entries never written by a first source read as undefined. Write sample_format only
// while the block is idle.
module multi_source_float_sum_accumulator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic [31:0] sample_bits,
	input  logic [9:0]  position,
	input  logic        first_source,
	input  logic        last_source,
	input  logic        push,
	output logic        full,
	output logic [31:0] sum_bits,
	output logic [9:0]  out_position,
	output logic        empty,
	input  logic        pop
);

	logic fmt_q;
	logic item_pop, item_empty;
	msfsa_pkg::item_t item;

	assign pready = 1'b1;
	assign prdata = (paddr == 3'd0) ? {31'd0, fmt_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fmt_q <= msfsa_pkg::FMT_HALF;
		else if (psel && penable && pwrite && pready && paddr == 3'd0) fmt_q <= pwdata[0];
	end

	msfsa_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_format(fmt_q),
		.sample_bits  (sample_bits),
		.position     (position),
		.first_source (first_source),
		.last_source  (last_source),
		.push         (push),
		.full         (full),
		.item_pop     (item_pop),
		.item_empty   (item_empty),
		.item         (item)
	);

	msfsa_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_format(fmt_q),
		.item_pop     (item_pop),
		.item_empty   (item_empty),
		.item         (item),
		.empty        (empty),
		.pop          (pop),
		.sum_bits     (sum_bits),
		.out_position (out_position)
	);

endmodule

// File: verif/tb.sv
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 600000;

	typedef struct {
		logic [31:0] sum;
		logic [9:0]  pos;
	} sum_exp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic [31:0] sample_bits = '0;
	logic [9:0]  position = '0;
	logic        first_source = 1'b0;
	logic        last_source = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [31:0] sum_bits;
	logic [9:0]  out_position;
	logic        empty;
	logic        pop = 1'b0;

	multi_source_float_sum_accumulator dut (.*);

	always #5 clk = ~clk;

	// predictor state
	logic [31:0] acc_store [msfsa_pkg::STORE_DEPTH];
	bit          entry_written [msfsa_pkg::STORE_DEPTH];
	logic        fmt_now = msfsa_pkg::FMT_HALF;
	sum_exp_t    pending_sums[$];
	int          errors = 0;
	int          sums_seen = 0;
	int          items_sent = 0;
	int          cycles = 0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		errors++;
		$display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want, sums_seen);
	endtask

	function automatic bit is_nan32(input logic [31:0] b);
		return b[30:23] == 8'hff && b[22:0] != 23'd0;
	endfunction

	function automatic logic [31:0] widen_half(input logic [15:0] h);
		logic [31:0] sgn;
		logic [31:0] man;
		int          shifts;
		sgn = {h[15], 31'b0};
		man = {22'b0, h[9:0]};
		shifts = 0;
		if (h[14:10] == 5'd0) begin
			if (man == 0) return sgn;
			man = man << 1;
			while (man[10] == 1'b0) begin
				man = man << 1;
				shifts++;
			end
			return sgn + ((32'd112 - shifts) << 23) + ((man & 32'h3ff) << 13);
		end
		if (h[14:10] == 5'h1f) return sgn + 32'h7f80_0000 + (man << 13);
		return sgn + (({17'b0, h[14:0]} + 32'h1_c000) << 13);
	endfunction

	function automatic logic [15:0] narrow_to_half(input logic [31:0] f);
		logic [31:0] sgn;
		logic [31:0] ex;
		logic [31:0] man;
		logic [31:0] r;
		sgn = {16'b0, f[31], 15'b0};
		ex = f & 32'h7f80_0000;
		if (ex >= 32'h4780_0000) begin
			if (ex == 32'h7f80_0000 && f[22:0] != 0) begin
				r = 32'h7c00 + ({9'b0, f[22:0]} >> 13);
				if (r == 32'h7c00) r++;
				return 16'(sgn + r);
			end
			return 16'(sgn + 32'h7c00);
		end
		if (ex <= 32'h3800_0000) begin
			if (ex < 32'h3300_0000) return 16'(sgn);
			ex = ex >> 23;
			man = (32'h0080_0000 + {9'b0, f[22:0]}) >> (32'd113 - ex);
			man = man + 32'h1000;
			return 16'(sgn + (man >> 13));
		end
		man = {9'b0, f[22:0]} + 32'h1000;
		return 16'(sgn + ((ex - 32'h3800_0000) >> 13) + (man >> 13));
	endfunction

	// single-precision add, round to nearest even, denormals kept
	function automatic logic [31:0] add_f32(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] big;
		logic [31:0] sml;
		logic [26:0] mb;
		logic [26:0] ms;
		logic [27:0] m;
		logic [24:0] mm;
		logic        stk;
		logic        up;
		int          eb;
		int          es;
		int          d;
		if (is_nan32(a)) return a | 32'h0040_0000;
		if (is_nan32(b)) return b | 32'h0040_0000;
		if (a[30:23] == 8'hff) begin
			if (b[30:23] == 8'hff && a[31] != b[31]) return msfsa_pkg::QNAN_DEFAULT;
			return a;
		end
		if (b[30:23] == 8'hff) return b;
		if (a[30:0] >= b[30:0]) begin
			big = a;
			sml = b;
		end else begin
			big = b;
			sml = a;
		end
		eb = (big[30:23] == 0) ? 1 : int'(big[30:23]);
		es = (sml[30:23] == 0) ? 1 : int'(sml[30:23]);
		mb = {big[30:23] != 0, big[22:0], 3'b0};
		ms = {sml[30:23] != 0, sml[22:0], 3'b0};
		d = eb - es;
		if (d >= 27) begin
			ms = {26'b0, |ms};
		end else if (d > 0) begin
			stk = |(ms & ((27'd1 << d) - 27'd1));
			ms = (ms >> d) | {26'b0, stk};
		end
		if (big[31] == sml[31]) m = {1'b0, mb} + {1'b0, ms};
		else m = {1'b0, mb} - {1'b0, ms};
		if (m == 0) return (big[31] == sml[31]) ? {big[31], 31'b0} : 32'd0;
		if (m[27]) begin
			m = (m >> 1) | {27'b0, m[0]};
			eb++;
		end else begin
			while (!m[26] && eb > 1) begin
				m = m << 1;
				eb--;
			end
		end
		up = m[2] && (m[1] || m[0] || m[3]);
		mm = {1'b0, m[26:3]} + {24'b0, up};
		if (mm[24]) begin
			mm = mm >> 1;
			eb++;
		end
		if (eb >= 255) return {big[31], 8'hff, 23'b0};
		if (!mm[23]) eb = 0;
		return {big[31], 8'(eb), mm[22:0]};
	endfunction

	task automatic predict_item(input msfsa_pkg::item_t it);
		logic [31:0] smp;
		logic [31:0] base;
		logic [31:0] s;
		sum_exp_t    e;
		smp = (fmt_now == msfsa_pkg::FMT_HALF) ? widen_half(it.sample[15:0]) : it.sample;
		base = it.first_source ? 32'd0 : acc_store[it.position];
		s = add_f32(base, smp);
		acc_store[it.position] = s;
		if (it.last_source) begin
			e.sum = (fmt_now == msfsa_pkg::FMT_HALF) ? {16'b0, narrow_to_half(s)} : s;
			e.pos = it.position;
			pending_sums.push_back(e);
		end
	endtask

	function automatic int short_or_long_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_item(input msfsa_pkg::item_t it, input bit allow_gap);
		int gap;
		gap = allow_gap ? short_or_long_gap() : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		sample_bits <= it.sample;
		position <= it.position;
		first_source <= it.first_source;
		last_source <= it.last_source;
		do @(posedge clk); while (full);
		entry_written[it.position] = 1'b1;
		predict_item(it);
		items_sent++;
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending_sums.size() != 0) @(posedge clk);
		// items without a result may still be queued or in the back end
		repeat (30) @(posedge clk);
	endtask

	task automatic write_format(input logic fmt);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'd0;
		pwdata <= {31'($urandom()), fmt};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		fmt_now = fmt;
		@(posedge clk);
	endtask

	function automatic logic [15:0] pick_half();
		logic [15:0] specials [12] = '{16'h0000, 16'h8000, 16'h7c00, 16'hfc00, 16'h7e01,
			16'hfd55, 16'h7bff, 16'hfbff, 16'h0001, 16'h83ff, 16'h0400, 16'h3c00};
		if ($urandom_range(0, 4) == 0) return specials[$urandom_range(0, 11)];
		return 16'($urandom());
	endfunction

	function automatic logic [31:0] pick_single();
		logic [31:0] specials [10] = '{32'h0, 32'h8000_0000, 32'h7f80_0000, 32'hff80_0000,
			32'h7fa0_0001, 32'hffc0_1234, 32'h7f7f_ffff, 32'h0000_0001, 32'h807f_ffff,
			32'h3f80_0000};
		if ($urandom_range(0, 4) == 0) return specials[$urandom_range(0, 9)];
		return $urandom();
	endfunction

	function automatic logic [31:0] pick_sample();
		if (fmt_now == msfsa_pkg::FMT_HALF) return {16'($urandom()), pick_half()};
		return pick_single();
	endfunction

	task automatic send_sum(input logic [9:0] pos, input logic [31:0] vals [$]);
		msfsa_pkg::item_t it;
		foreach (vals[i]) begin
			it.sample = vals[i];
			it.position = pos;
			it.first_source = (i == 0);
			it.last_source = (i == vals.size() - 1);
			send_item(it, 1'b0);
		end
	endtask

	task automatic test_directed_half();
		write_format(msfsa_pkg::FMT_HALF);
		send_sum(10'd0, '{32'hffff_3c00, 32'h0000_3c00});    // 1 + 1
		send_sum(10'd1023, '{32'h8000, 32'h8000});           // negative zero first
		send_sum(10'd5, '{32'h7bff, 32'h7bff});              // overflow to infinity
		send_sum(10'd6, '{32'h7c00, 32'hfc00});              // inf minus inf
		send_sum(10'd7, '{32'h7d01, 32'h3c00, 32'hfe00});    // NaN entry kept
		send_sum(10'd8, '{32'h0001, 32'h8401});              // tiny denormal sample, smallest normal result
		send_sum(10'd9, '{32'h3c00, 32'h1000});              // rounding on narrowing
		drain();
	endtask

	task automatic test_directed_single();
		write_format(msfsa_pkg::FMT_SINGLE);
		send_sum(10'd0, '{32'h7f7f_ffff, 32'h7f7f_ffff});    // overflow
		send_sum(10'd1, '{32'h8000_0000});                   // negative zero first
		send_sum(10'd2, '{32'h3f80_0000, 32'h7fa0_0000});    // NaN sample
		send_sum(10'd3, '{32'hff80_0000, 32'h7f80_0000});    // opposite infinities
		send_sum(10'd4, '{32'h0000_0001, 32'h8000_0003});    // denormals
		send_sum(10'd1023, '{32'h3f80_0000, 32'h3380_0000, 32'hbf80_0000});
		drain();
	endtask

	// interleaved runs of sources over a handful of live positions plus some noise
	task automatic test_random(input int n);
		logic [9:0]       live_pos [4];
		int               live_left [4];
		int               live_idx [4];
		msfsa_pkg::item_t it;
		int               k;
		for (int i = 0; i < 4; i++) live_left[i] = 0;
		for (int n_done = 0; n_done < n; n_done++) begin
			it.sample = pick_sample();
			if ($urandom_range(0, 9) == 0) begin
				it.position = 10'($urandom());
				it.first_source = $urandom_range(0, 1) || !entry_written[it.position];
				it.last_source = 1'($urandom_range(0, 1));
			end else begin
				k = $urandom_range(0, 3);
				if (live_left[k] == 0) begin
					live_pos[k] = ($urandom_range(0, 3) == 0) ?
						10'($urandom_range(0, 7)) : 10'($urandom());
					for (int j = 0; j < 4; j++)
						if (j != k && live_left[j] != 0 && live_pos[j] == live_pos[k])
							live_pos[k] = live_pos[k] + 10'd11 * 10'(j + 1);
					live_left[k] = $urandom_range(1, 5);
					live_idx[k] = 0;
				end
				it.position = live_pos[k];
				it.first_source = (live_idx[k] == 0);
				live_idx[k]++;
				live_left[k]--;
				it.last_source = (live_left[k] == 0);
			end
			send_item(it, 1'b1);
		end
		drain();
	endtask

	task automatic test_format_switching();
		for (int p = 0; p < 6; p++) begin
			write_format(p[0] ? msfsa_pkg::FMT_SINGLE : msfsa_pkg::FMT_HALF);
			test_random(60);
		end
	endtask

	// result side: random pop with occasional long stalls
	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			pop <= 1'b0;
		end else if ($urandom_range(0, 49) == 0) begin
			stall_left <= $urandom_range(10, 40);
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(0, 99) < 70);
		end
	end

	always @(posedge clk) begin
		sum_exp_t e;
		if (arst_n && pop && !empty) begin
			sums_seen++;
			if (pending_sums.size() == 0) begin
				report_mismatch("unexpected result at position", 32'(out_position), 32'd0);
			end else begin
				e = pending_sums.pop_front();
				if (sum_bits !== e.sum) report_mismatch("sum_bits", sum_bits, e.sum);
				if (out_position !== e.pos)
					report_mismatch("out_position", 32'(out_position), 32'(e.pos));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb failed");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_half();
		test_directed_single();
		write_format(msfsa_pkg::FMT_HALF);
		test_random(380);
		write_format(msfsa_pkg::FMT_SINGLE);
		test_random(380);
		test_format_switching();
		$display("sent %0d samples, checked %0d sums in half and single format,", items_sent,
			sums_seen);
		$display("with format changes between phases and random stalls on both sides");
		if (errors == 0 && pending_sums.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
